FILE: design/str_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// str_pkg
// Shared types and constants of the segmented transfer receiver.
// ----------------------------------------------------------------------------
package str_pkg;

   localparam int NUM_CHANNELS_DEF = 3;
   localparam int NUM_BUFFERS_DEF  = 2;

   localparam int CHANNEL_W = 2;
   localparam int FLAG_W    = 16;
   localparam int SERIAL_W  = 32;
   localparam int AREA_W    = 3;
   localparam int REGION_W  = 2;
   localparam int OFFSET_W  = 20;
   localparam int ERR_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 20;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_START_MARKER  = 3'd0,
      CFG_SERVICE_ID    = 3'd1,
      CFG_CONTINUE_CODE = 3'd2,
      CFG_GLOBAL_LEN    = 3'd3,
      CFG_INPUT_LEN     = 3'd4,
      CFG_OUTPUT_LEN    = 3'd5,
      CFG_APPEND_LEN    = 3'd6
   } cfg_index_type;

   localparam logic [AREA_W-1:0] AREA_GLOBAL = 3'd0;
   localparam logic [AREA_W-1:0] AREA_INPUT  = 3'd1;
   localparam logic [AREA_W-1:0] AREA_OUTPUT = 3'd2;
   localparam logic [AREA_W-1:0] AREA_APPEND = 3'd3;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK         = 2'd0,
      ERR_RETRANSMIT = 2'd1,
      ERR_CRC_LEN    = 2'd2
   } err_code_type;

   // classified segment header, front to back
   typedef struct packed {
      logic [CHANNEL_W-1:0] channel;
      logic                 hdr_match;
      logic                 cont;
      logic                 serial_zero;
      logic [SERIAL_W-1:0]  serial;
      logic                 is_append;
      logic [REGION_W-1:0]  region;
      logic [OFFSET_W-1:0]  offset;
      logic                 region_ok;
      logic                 crc_len_ok;
      logic                 buf_free;
   } seg_entry_type;

   typedef struct packed {
      logic                write_go;
      logic                write_buffer;
      logic [REGION_W-1:0] write_region;
      logic [OFFSET_W-1:0] write_offset;
      logic                commit;
      logic                read_valid;
      logic                read_buffer;
      logic                ack_flag;
      logic [ERR_W-1:0]    error_code;
      logic [SERIAL_W-1:0] ack_serial;
   } result_type;

endpackage
`default_nettype wire

FILE: design/str_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// str_front
// Holds the configuration registers, takes segment headers and classifies
// them against the configuration; drops headers for unknown channels.
// ----------------------------------------------------------------------------
module str_front #(
   parameter int NUM_CHANNELS = str_pkg::NUM_CHANNELS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [str_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [str_pkg::CSR_DAT_W-1:0]    csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [str_pkg::CHANNEL_W-1:0]    req_channel,
   input  wire logic [str_pkg::FLAG_W-1:0]       req_start_flag,
   input  wire logic [str_pkg::FLAG_W-1:0]       req_service_code,
   input  wire logic [str_pkg::SERIAL_W-1:0]     req_serial_num,
   input  wire logic [str_pkg::FLAG_W-1:0]       req_transfer_flag,
   input  wire logic [str_pkg::AREA_W-1:0]       req_area_class,
   input  wire logic [str_pkg::OFFSET_W-1:0]     req_seg_offset,
   input  wire logic                             req_crc_ok,
   input  wire logic                             req_length_ok,
   input  wire logic                             req_buffer_free,
   input  wire logic                             queue_full,
   output logic                                  queue_push,
   output str_pkg::seg_entry_type                queue_entry
);

   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int EXT_W = CH_W + str_pkg::CHANNEL_W;

   logic [str_pkg::FLAG_W-1:0]   start_marker_ff, service_id_ff, continue_code_ff;
   logic [str_pkg::OFFSET_W-1:0] global_len_ff, input_len_ff, output_len_ff, append_len_ff;
   logic [str_pkg::OFFSET_W-1:0] bound;
   logic                         area_known;
   logic [EXT_W-1:0]             ch_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff  <= '0;
         service_id_ff    <= '0;
         continue_code_ff <= '0;
         global_len_ff    <= '0;
         input_len_ff     <= '0;
         output_len_ff    <= '0;
         append_len_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            str_pkg::CFG_START_MARKER:  start_marker_ff  <= csr_wdata[str_pkg::FLAG_W-1:0];
            str_pkg::CFG_SERVICE_ID:    service_id_ff    <= csr_wdata[str_pkg::FLAG_W-1:0];
            str_pkg::CFG_CONTINUE_CODE: continue_code_ff <= csr_wdata[str_pkg::FLAG_W-1:0];
            str_pkg::CFG_GLOBAL_LEN:    global_len_ff    <= csr_wdata;
            str_pkg::CFG_INPUT_LEN:     input_len_ff     <= csr_wdata;
            str_pkg::CFG_OUTPUT_LEN:    output_len_ff    <= csr_wdata;
            str_pkg::CFG_APPEND_LEN:    append_len_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      area_known = 1'b1;
      unique case (req_area_class)
         str_pkg::AREA_GLOBAL: bound = global_len_ff;
         str_pkg::AREA_INPUT:  bound = input_len_ff;
         str_pkg::AREA_OUTPUT: bound = output_len_ff;
         str_pkg::AREA_APPEND: bound = append_len_ff;
         default: begin
            bound      = '0;
            area_known = 1'b0;
         end
      endcase
   end

   assign ch_ext    = EXT_W'(req_channel);
   assign req_stall = queue_full;
   assign queue_push = req_valid && !queue_full && (ch_ext < EXT_W'(NUM_CHANNELS));

   always_comb begin
      queue_entry.channel     = req_channel;
      queue_entry.hdr_match   = (req_start_flag == start_marker_ff) &&
                                (req_service_code == service_id_ff);
      queue_entry.cont        = (req_transfer_flag == continue_code_ff);
      queue_entry.serial_zero = (req_serial_num == '0);
      queue_entry.serial      = req_serial_num;
      queue_entry.is_append   = (req_area_class == str_pkg::AREA_APPEND);
      queue_entry.region      = req_area_class[str_pkg::REGION_W-1:0];
      queue_entry.offset      = req_seg_offset;
      queue_entry.region_ok   = area_known && (req_seg_offset < bound);
      queue_entry.crc_len_ok  = req_crc_ok && req_length_ok;
      queue_entry.buf_free    = req_buffer_free;
   end

endmodule
`default_nettype wire

FILE: design/str_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// str_queue
// Short queue of classified headers between front and back.
// ----------------------------------------------------------------------------
module str_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire str_pkg::seg_entry_type push_data,
   output logic                        full,
   input  wire logic                   pop,
   output str_pkg::seg_entry_type      pop_data,
   output logic                        empty
);

   str_pkg::seg_entry_type               entries_ff [str_pkg::QUEUE_DEPTH];
   logic [str_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [str_pkg::QUEUE_CNT_W-1:0]      count_ff;
   logic                                 do_push, do_pop;

   localparam logic [str_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      str_pkg::QUEUE_PTR_W'(str_pkg::QUEUE_DEPTH - 1);
   localparam logic [str_pkg::QUEUE_PTR_W-1:0] PTR_ONE = str_pkg::QUEUE_PTR_W'(1);
   localparam logic [str_pkg::QUEUE_CNT_W-1:0] CNT_ONE = str_pkg::QUEUE_CNT_W'(1);

   assign full     = (count_ff == str_pkg::QUEUE_CNT_W'(str_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_ONE;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_ONE;
         end
      end
   end

endmodule
`default_nettype wire

FILE: design/str_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// str_back
// Per-channel sequence tracking, write grant, double-buffer swap and
// acknowledgement; results leave through an output register.
// ----------------------------------------------------------------------------
module str_back #(
   parameter int NUM_CHANNELS = str_pkg::NUM_CHANNELS_DEF,
   parameter int NUM_BUFFERS  = str_pkg::NUM_BUFFERS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire str_pkg::seg_entry_type entry,
   input  wire logic                   queue_empty,
   output logic                        queue_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output str_pkg::result_type         result
);

   localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int EXT_W = CH_W + str_pkg::CHANNEL_W;
   localparam int BUF_W = $clog2(NUM_BUFFERS);
   localparam logic [BUF_W-1:0] LAST_BUF = BUF_W'(NUM_BUFFERS - 1);
   localparam logic [BUF_W-1:0] BUF_ONE  = BUF_W'(1);

   logic [str_pkg::SERIAL_W-1:0] expected_ff [NUM_CHANNELS];
   logic [str_pkg::SERIAL_W-1:0] echo_ff     [NUM_CHANNELS];
   logic                         finish_ff   [NUM_CHANNELS];
   logic [BUF_W-1:0]             wr_idx_ff   [NUM_CHANNELS];
   logic                         rd_pres_ff  [NUM_CHANNELS];
   logic [BUF_W-1:0]             rd_idx_ff   [NUM_CHANNELS];

   logic                         rsp_valid_ff;
   str_pkg::result_type          rsp_ff, rsp_in;

   logic [EXT_W-1:0]             ch_ext;
   logic [CH_W-1:0]              ch;
   logic                         hdr_ok, finish_in, go, commit;
   str_pkg::err_code_type        err;
   logic [str_pkg::SERIAL_W-1:0] expected_in, echo_in;

   assign ch_ext    = EXT_W'(entry.channel);
   assign ch        = ch_ext[CH_W-1:0];
   assign queue_pop = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign result    = rsp_ff;

   always_comb begin
      hdr_ok = entry.hdr_match && (entry.serial_zero || entry.serial == expected_ff[ch]);

      expected_in = expected_ff[ch];
      echo_in     = echo_ff[ch];
      finish_in   = finish_ff[ch];
      if (hdr_ok) begin
         echo_in   = entry.serial;
         finish_in = !entry.cont;
         if (entry.serial_zero) begin
            expected_in = 32'd1;
         end else if (!entry.cont && entry.is_append) begin
            expected_in = '0;
         end else begin
            expected_in = expected_ff[ch] + 32'd1;
         end
      end

      if (!hdr_ok) begin
         err = str_pkg::ERR_RETRANSMIT;
      end else if (!entry.crc_len_ok) begin
         err = str_pkg::ERR_CRC_LEN;
      end else if (!entry.region_ok || !entry.buf_free) begin
         err = str_pkg::ERR_RETRANSMIT;
      end else begin
         err = str_pkg::ERR_OK;
      end
      if (err != str_pkg::ERR_OK) begin
         expected_in = '0;
      end

      go     = (err == str_pkg::ERR_OK);
      commit = go && finish_in && entry.is_append;

      rsp_in.write_go     = go;
      rsp_in.write_buffer = go ? wr_idx_ff[ch][0] : 1'b0;
      rsp_in.write_region = go ? entry.region : '0;
      rsp_in.write_offset = go ? entry.offset : '0;
      rsp_in.commit       = commit;
      rsp_in.read_valid   = commit ? 1'b1 : rd_pres_ff[ch];
      rsp_in.read_buffer  = commit ? wr_idx_ff[ch][0] : rd_idx_ff[ch][0];
      rsp_in.ack_flag     = go;
      rsp_in.error_code   = err;
      rsp_in.ack_serial   = echo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            expected_ff[i] <= '0;
            echo_ff[i]     <= '0;
            finish_ff[i]   <= 1'b0;
            wr_idx_ff[i]   <= '0;
            rd_pres_ff[i]  <= 1'b0;
            rd_idx_ff[i]   <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (queue_pop) begin
            expected_ff[ch] <= expected_in;
            echo_ff[ch]     <= echo_in;
            finish_ff[ch]   <= finish_in;
            if (commit) begin
               rd_idx_ff[ch]  <= wr_idx_ff[ch];
               rd_pres_ff[ch] <= 1'b1;
               wr_idx_ff[ch]  <= (wr_idx_ff[ch] == LAST_BUF) ? '0 : wr_idx_ff[ch] + BUF_ONE;
            end
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

FILE: design/segmented_transfer_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_transfer_receiver
// Header check, sequence tracking and double-buffer control for received
// real-time data segments, one header per transfer.
// ----------------------------------------------------------------------------
// Takes one segment header per clock while req_stall is low and returns one
// result per header, in order, after the queue and the back end's output
// register. The rate is set by the per-channel state update in the back end,
// which handles one header a cycle while rsp_stall is low. The front end
// classifies headers against the configuration and feeds a two-entry queue,
// so req_stall rises only when that queue is full. Headers for a channel
// number at or above NUM_CHANNELS are taken and dropped with no result.
// Configuration writes belong in idle periods.
module segmented_transfer_receiver #(
   parameter int NUM_CHANNELS = str_pkg::NUM_CHANNELS_DEF,
   parameter int NUM_BUFFERS  = str_pkg::NUM_BUFFERS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_en,
   input  wire logic [str_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [str_pkg::CSR_DAT_W-1:0]    csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [str_pkg::CHANNEL_W-1:0]    req_channel,
   input  wire logic [str_pkg::FLAG_W-1:0]       req_start_flag,
   input  wire logic [str_pkg::FLAG_W-1:0]       req_service_code,
   input  wire logic [str_pkg::SERIAL_W-1:0]     req_serial_num,
   input  wire logic [str_pkg::FLAG_W-1:0]       req_transfer_flag,
   input  wire logic [str_pkg::AREA_W-1:0]       req_area_class,
   input  wire logic [str_pkg::OFFSET_W-1:0]     req_seg_offset,
   input  wire logic                             req_crc_ok,
   input  wire logic                             req_length_ok,
   input  wire logic                             req_buffer_free,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_write_go,
   output logic                                  rsp_write_buffer,
   output logic [str_pkg::REGION_W-1:0]          rsp_write_region,
   output logic [str_pkg::OFFSET_W-1:0]          rsp_write_offset,
   output logic                                  rsp_commit,
   output logic                                  rsp_read_valid,
   output logic                                  rsp_read_buffer,
   output logic                                  rsp_ack_flag,
   output logic [str_pkg::ERR_W-1:0]             rsp_error_code,
   output logic [str_pkg::SERIAL_W-1:0]          rsp_ack_serial
);

   str_pkg::seg_entry_type push_entry, pop_entry;
   str_pkg::result_type    result;
   logic                   queue_push, queue_full, queue_pop, queue_empty;

   str_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_channel       (req_channel),
      .req_start_flag    (req_start_flag),
      .req_service_code  (req_service_code),
      .req_serial_num    (req_serial_num),
      .req_transfer_flag (req_transfer_flag),
      .req_area_class    (req_area_class),
      .req_seg_offset    (req_seg_offset),
      .req_crc_ok        (req_crc_ok),
      .req_length_ok     (req_length_ok),
      .req_buffer_free   (req_buffer_free),
      .queue_full        (queue_full),
      .queue_push        (queue_push),
      .queue_entry       (push_entry)
   );

   str_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (push_entry),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_data  (pop_entry),
      .empty     (queue_empty)
   );

   str_back #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .NUM_BUFFERS  (NUM_BUFFERS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (pop_entry),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .result      (result)
   );

   assign rsp_write_go     = result.write_go;
   assign rsp_write_buffer = result.write_buffer;
   assign rsp_write_region = result.write_region;
   assign rsp_write_offset = result.write_offset;
   assign rsp_commit       = result.commit;
   assign rsp_read_valid   = result.read_valid;
   assign rsp_read_buffer  = result.read_buffer;
   assign rsp_ack_flag     = result.ack_flag;
   assign rsp_error_code   = result.error_code;
   assign rsp_ack_serial   = result.ack_serial;

endmodule
`default_nettype wire

FILE: tb/segmented_transfer_receiver_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segmented_transfer_receiver_tb
// Self-checking bench for the segmented transfer receiver. Segment headers are
// driven one transfer at a time. A cycle-free model of the per-channel
// sequence and double-buffer state predicts each acknowledgement, and every
// result is compared field by field in arrival order. A short directed pass
// covers header rejects, bad CRC or length, region bounds, a busy buffer,
// buffer swaps and the unused channel. Random passes follow under several
// register settings and three handshake idle profiles.
// ----------------------------------------------------------------------------

typedef struct {
   bit [str_pkg::CHANNEL_W-1:0] channel;
   bit [str_pkg::FLAG_W-1:0]    start_flag;
   bit [str_pkg::FLAG_W-1:0]    service_code;
   bit [str_pkg::SERIAL_W-1:0]  serial_num;
   bit [str_pkg::FLAG_W-1:0]    transfer_flag;
   bit [str_pkg::AREA_W-1:0]    area_class;
   bit [str_pkg::OFFSET_W-1:0]  seg_offset;
   bit                          crc_ok;
   bit                          length_ok;
   bit                          buffer_free;
} segment_hdr_type;

class ack_scoreboard;
   bit [str_pkg::FLAG_W-1:0]   start_marker;
   bit [str_pkg::FLAG_W-1:0]   service_id;
   bit [str_pkg::FLAG_W-1:0]   continue_code;
   bit [str_pkg::OFFSET_W-1:0] region_len [4];

   bit [str_pkg::SERIAL_W-1:0] next_serial  [str_pkg::NUM_CHANNELS_DEF];
   bit [str_pkg::SERIAL_W-1:0] echo_serial  [str_pkg::NUM_CHANNELS_DEF];
   bit                         finish_seen  [str_pkg::NUM_CHANNELS_DEF];
   int                         write_idx    [str_pkg::NUM_CHANNELS_DEF];
   bit                         read_present [str_pkg::NUM_CHANNELS_DEF];
   int                         read_idx     [str_pkg::NUM_CHANNELS_DEF];

   str_pkg::result_type pending_acks[$];
   int mismatches;
   int checked;
   int commits;
   int naks;

   function void set_register(str_pkg::cfg_index_type idx, bit [str_pkg::CSR_DAT_W-1:0] value);
      case (idx)
         str_pkg::CFG_START_MARKER:  start_marker  = value[15:0];
         str_pkg::CFG_SERVICE_ID:    service_id    = value[15:0];
         str_pkg::CFG_CONTINUE_CODE: continue_code = value[15:0];
         str_pkg::CFG_GLOBAL_LEN:    region_len[0] = value;
         str_pkg::CFG_INPUT_LEN:     region_len[1] = value;
         str_pkg::CFG_OUTPUT_LEN:    region_len[2] = value;
         str_pkg::CFG_APPEND_LEN:    region_len[3] = value;
         default: ;
      endcase
   endfunction

   function void note_transfer(segment_hdr_type s);
      str_pkg::result_type  r;
      str_pkg::err_code_type err;
      bit hdr_ok;
      bit cont;
      int c;
      if (s.channel >= str_pkg::NUM_CHANNELS_DEF) return;
      c = int'(s.channel);
      hdr_ok = 1'b0;
      cont = (s.transfer_flag == continue_code);
      if (s.start_flag == start_marker && s.service_code == service_id) begin
         if (s.serial_num == 0) begin
            next_serial[c] = 1;
            hdr_ok = 1'b1;
         end else if (s.serial_num == next_serial[c]) begin
            if (!cont && s.area_class == str_pkg::AREA_APPEND) next_serial[c] = 0;
            else next_serial[c] = next_serial[c] + 1;
            hdr_ok = 1'b1;
         end
         if (hdr_ok) begin
            echo_serial[c] = s.serial_num;
            finish_seen[c] = !cont;
         end
      end
      r = '0;
      if (!hdr_ok) err = str_pkg::ERR_RETRANSMIT;
      else if (!(s.crc_ok && s.length_ok)) err = str_pkg::ERR_CRC_LEN;
      else if (s.area_class > str_pkg::AREA_APPEND ||
               s.seg_offset >= region_len[s.area_class[1:0]]) err = str_pkg::ERR_RETRANSMIT;
      else if (!s.buffer_free) err = str_pkg::ERR_RETRANSMIT;
      else begin
         err = str_pkg::ERR_OK;
         r.write_go     = 1'b1;
         r.write_buffer = write_idx[c][0];
         r.write_region = s.area_class[1:0];
         r.write_offset = s.seg_offset;
         if (finish_seen[c] && s.area_class == str_pkg::AREA_APPEND) begin
            r.commit        = 1'b1;
            read_idx[c]     = write_idx[c];
            read_present[c] = 1'b1;
            write_idx[c]    = (write_idx[c] + 1) % str_pkg::NUM_BUFFERS_DEF;
         end
      end
      if (err != str_pkg::ERR_OK) next_serial[c] = 0;
      r.read_valid  = read_present[c];
      r.read_buffer = read_idx[c][0];
      r.ack_flag    = (err == str_pkg::ERR_OK);
      r.error_code  = err;
      r.ack_serial  = echo_serial[c];
      pending_acks.push_back(r);
   endfunction

   function void show_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) $display("   %s: expected %0h, got %0h", name, want, got);
   endfunction

   function void check_result(str_pkg::result_type got);
      str_pkg::result_type want;
      if (pending_acks.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("%0t: result with no transfer outstanding", $time);
         return;
      end
      want = pending_acks.pop_front();
      checked++;
      if (got.commit === 1'b1) commits++;
      if (got.ack_flag === 1'b0) naks++;
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: mismatch on result %0d", $time, checked);
            show_field("write_go", want.write_go, got.write_go);
            show_field("write_buffer", want.write_buffer, got.write_buffer);
            show_field("write_region", want.write_region, got.write_region);
            show_field("write_offset", want.write_offset, got.write_offset);
            show_field("commit", want.commit, got.commit);
            show_field("read_valid", want.read_valid, got.read_valid);
            show_field("read_buffer", want.read_buffer, got.read_buffer);
            show_field("ack_flag", want.ack_flag, got.ack_flag);
            show_field("error_code", want.error_code, got.error_code);
            show_field("ack_serial", want.ack_serial, got.ack_serial);
         end
      end
   endfunction
endclass

module segmented_transfer_receiver_tb;
   import str_pkg::*;

   localparam int NCH         = NUM_CHANNELS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [CSR_DAT_W-1:0] csr_wdata    = '0;

   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [CHANNEL_W-1:0] req_channel       = '0;
   logic [FLAG_W-1:0]    req_start_flag    = '0;
   logic [FLAG_W-1:0]    req_service_code  = '0;
   logic [SERIAL_W-1:0]  req_serial_num    = '0;
   logic [FLAG_W-1:0]    req_transfer_flag = '0;
   logic [AREA_W-1:0]    req_area_class    = '0;
   logic [OFFSET_W-1:0]  req_seg_offset    = '0;
   logic                 req_crc_ok        = 1'b0;
   logic                 req_length_ok     = 1'b0;
   logic                 req_buffer_free   = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_write_go;
   logic                 rsp_write_buffer;
   logic [REGION_W-1:0]  rsp_write_region;
   logic [OFFSET_W-1:0]  rsp_write_offset;
   logic                 rsp_commit;
   logic                 rsp_read_valid;
   logic                 rsp_read_buffer;
   logic                 rsp_ack_flag;
   logic [ERR_W-1:0]     rsp_error_code;
   logic [SERIAL_W-1:0]  rsp_ack_serial;

   result_type    rsp_sample;
   ack_scoreboard sb;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   int            cycle_count    = 0;
   int            unused_sent    = 0;
   int            settings_run   = 0;

   segmented_transfer_receiver dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_channel       (req_channel),
      .req_start_flag    (req_start_flag),
      .req_service_code  (req_service_code),
      .req_serial_num    (req_serial_num),
      .req_transfer_flag (req_transfer_flag),
      .req_area_class    (req_area_class),
      .req_seg_offset    (req_seg_offset),
      .req_crc_ok        (req_crc_ok),
      .req_length_ok     (req_length_ok),
      .req_buffer_free   (req_buffer_free),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_go      (rsp_write_go),
      .rsp_write_buffer  (rsp_write_buffer),
      .rsp_write_region  (rsp_write_region),
      .rsp_write_offset  (rsp_write_offset),
      .rsp_commit        (rsp_commit),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_buffer   (rsp_read_buffer),
      .rsp_ack_flag      (rsp_ack_flag),
      .rsp_error_code    (rsp_error_code),
      .rsp_ack_serial    (rsp_ack_serial)
   );

   always #10 clock = ~clock;

   assign rsp_sample = {rsp_write_go, rsp_write_buffer, rsp_write_region, rsp_write_offset,
                        rsp_commit, rsp_read_valid, rsp_read_buffer, rsp_ack_flag,
                        rsp_error_code, rsp_ack_serial};

   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_sample);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic write_register(cfg_index_type idx, logic [CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value;
      @(negedge clock);
      csr_write_en = 1'b0;
      sb.set_register(idx, value);
   endtask

   task automatic apply_setting(logic [19:0] marker, logic [19:0] service, logic [19:0] cont,
                                logic [19:0] glen, logic [19:0] ilen, logic [19:0] olen,
                                logic [19:0] alen);
      write_register(CFG_START_MARKER, marker);
      write_register(CFG_SERVICE_ID, service);
      write_register(CFG_CONTINUE_CODE, cont);
      write_register(CFG_GLOBAL_LEN, glen);
      write_register(CFG_INPUT_LEN, ilen);
      write_register(CFG_OUTPUT_LEN, olen);
      write_register(CFG_APPEND_LEN, alen);
      settings_run++;
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_segment(segment_hdr_type h);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_channel       = h.channel;
      req_start_flag    = h.start_flag;
      req_service_code  = h.service_code;
      req_serial_num    = h.serial_num;
      req_transfer_flag = h.transfer_flag;
      req_area_class    = h.area_class;
      req_seg_offset    = h.seg_offset;
      req_crc_ok        = h.crc_ok;
      req_length_ok     = h.length_ok;
      req_buffer_free   = h.buffer_free;
      req_valid         = 1'b1;
      do @(posedge clock); while (req_stall);
      sb.note_transfer(h);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (sb.pending_acks.size() != 0) @(posedge clock);
      // transfers to the unused channel may still be in flight
      repeat (10) @(posedge clock);
   endtask

   function automatic segment_hdr_type good_segment(int ch, bit [31:0] serial, bit [15:0] tflag,
                                                    bit [2:0] area, bit [19:0] off);
      segment_hdr_type h;
      h.channel       = CHANNEL_W'(ch);
      h.start_flag    = sb.start_marker;
      h.service_code  = sb.service_id;
      h.serial_num    = serial;
      h.transfer_flag = tflag;
      h.area_class    = area;
      h.seg_offset    = off;
      h.crc_ok        = 1'b1;
      h.length_ok     = 1'b1;
      h.buffer_free   = 1'b1;
      return h;
   endfunction

   function automatic segment_hdr_type random_segment();
      segment_hdr_type h;
      int              c;
      int              pick;
      bit [19:0]       len;
      c = ($urandom_range(99) < 5) ? 3 : $urandom_range(NCH - 1);
      h.channel      = CHANNEL_W'(c);
      h.start_flag   = ($urandom_range(99) < 92) ? sb.start_marker : 16'($urandom);
      h.service_code = ($urandom_range(99) < 92) ? sb.service_id : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) h.serial_num = 0;
      else if (pick < 85 && c < NCH) h.serial_num = sb.next_serial[c];
      else h.serial_num = $urandom;
      h.transfer_flag = ($urandom_range(99) < 65) ? sb.continue_code : 16'($urandom);
      h.area_class = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 4)) : 3'($urandom_range(3));
      len = (h.area_class <= AREA_APPEND) ? sb.region_len[h.area_class[1:0]] : 20'($urandom);
      pick = $urandom_range(99);
      if (len != 0 && pick < 75) h.seg_offset = OFFSET_W'($urandom_range(len - 1));
      else if (pick < 85) h.seg_offset = OFFSET_W'(len - (pick % 2));
      else h.seg_offset = OFFSET_W'($urandom);
      h.crc_ok      = ($urandom_range(99) < 93);
      h.length_ok   = ($urandom_range(99) < 93);
      h.buffer_free = ($urandom_range(99) < 90);
      return h;
   endfunction

   task automatic run_random(int n);
      segment_hdr_type h;
      int              counted;
      counted = 0;
      while (counted < n) begin
         h = random_segment();
         send_segment(h);
         if (h.channel < NCH) counted++;
         else unused_sent++;
      end
   endtask

   task automatic run_directed();
      segment_hdr_type h;
      send_segment(good_segment(0, 0, 16'h0000, AREA_GLOBAL, 20'h0));
      send_segment(good_segment(0, 1, 16'h0000, AREA_INPUT, 20'h3F));
      // offset equal to the region length
      send_segment(good_segment(0, 2, 16'h0000, AREA_OUTPUT, 20'h40));
      // out-of-sequence serial
      send_segment(good_segment(0, 3, 16'h0000, AREA_GLOBAL, 20'h0));
      h = good_segment(0, 0, 16'h0000, AREA_GLOBAL, 20'h1);
      h.start_flag = 16'h0000;
      send_segment(h);
      h.start_flag = 16'hFFFF;
      send_segment(h);
      h = good_segment(0, 0, 16'h0000, AREA_GLOBAL, 20'h2);
      h.service_code = 16'hFFFF;
      send_segment(h);
      h = good_segment(0, 0, 16'h0000, AREA_INPUT, 20'h3);
      h.crc_ok = 1'b0;
      send_segment(h);
      h = good_segment(0, 0, 16'h0000, AREA_INPUT, 20'h4);
      h.length_ok = 1'b0;
      send_segment(h);
      send_segment(good_segment(0, 0, 16'h0000, 3'd4, 20'h0));
      send_segment(good_segment(0, 0, 16'h0000, 3'd7, 20'h0));
      h = good_segment(0, 0, 16'h0000, AREA_GLOBAL, 20'h5);
      h.buffer_free = 1'b0;
      send_segment(h);
      send_segment(good_segment(0, 0, 16'h0000, AREA_APPEND, 20'h0));
      // finishing append segment swaps buffers
      send_segment(good_segment(0, 1, 16'hFFFF, AREA_APPEND, 20'h1F));
      // finish without append: serial advances, no swap
      send_segment(good_segment(0, 0, 16'h8001, AREA_GLOBAL, 20'hFF));
      send_segment(good_segment(0, 1, 16'h0001, AREA_APPEND, 20'h10));
      send_segment(good_segment(3, 0, 16'h0000, AREA_GLOBAL, 20'h0));
      unused_sent++;
      send_segment(good_segment(1, 32'hFFFF_FFFF, 16'h0000, AREA_GLOBAL, 20'h0));
      send_segment(good_segment(1, 0, 16'h0000, AREA_GLOBAL, 20'h0));
      h = good_segment(1, 1, 16'hFFFF, AREA_APPEND, 20'h0);
      h.crc_ok = 1'b0;
      send_segment(h);
      send_segment(good_segment(2, 0, 16'hFFFF, AREA_APPEND, 20'hFFFFF));
      send_segment(good_segment(2, 0, 16'hFFFF, AREA_APPEND, 20'h0));
      send_segment(good_segment(2, 0, 16'h0000, AREA_OUTPUT, 20'h0));
      send_segment(good_segment(2, 1, 16'hFFFF, AREA_APPEND, 20'h1));
   endtask

   initial begin
      sb = new;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      recv_stall_pct = 30;
      apply_setting(20'hFA55A, 20'h00101, 20'h00000, 20'h00100, 20'h00040, 20'h00040,
                    20'h00020);
      run_directed();
      wait_drain();

      for (int p = 0; p < 6; p++) begin
         send_idle_pct  = (p < 2) ? 20 : (p < 4) ? 55 : 0;
         recv_stall_pct = (p < 2) ? 55 : (p < 4) ? 20 : 0;
         case (p)
            1: apply_setting(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                             20'hFFFFF, 20'hFFFFF);
            2: apply_setting(20'h0, 20'h0, 20'h0, 20'h0, 20'h3, 20'h0, 20'h10);
            4: apply_setting(20'($urandom), 20'($urandom), 20'($urandom),
                             20'h1, 20'h1, 20'h1, 20'h1);
            default: apply_setting(20'($urandom), 20'($urandom), 20'($urandom),
                                   20'($urandom_range(4096, 1)), 20'($urandom_range(4096, 1)),
                                   20'($urandom_range(4096, 1)), 20'($urandom_range(4096, 1)));
         endcase
         run_random(228);
         wait_drain();
      end

      $display("%0d acknowledgements checked (%0d NAK, %0d buffer commits), %0d segments to",
               sb.checked, sb.naks, sb.commits, unused_sent);
      $display("the unused channel, %0d register settings, %0d mismatches",
               settings_run, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_acks.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
